[rtl/etl_pkg.sv]
// Shared types, constants and helpers for the expression token lexer.
// No dependencies; used by etl_core, etl_rfifo and expression_token_lexer.
package etl_pkg;

    // Counter widths
    localparam int POSITION_BITS = 24;
    localparam int LINE_COL_BITS = 16;
    localparam int LEN_BITS      = 16;
    localparam int KW_BITS       = 3;

    // Result queue depth (must hold two pushes plus one draining entry)
    localparam int RES_DEPTH     = 4;
    localparam int RES_PTR_BITS  = $clog2(RES_DEPTH);

    // Output word: offset, length, line, column, padded to whole bytes
    localparam int TOKEN_BITS    = POSITION_BITS + LEN_BITS + 2 * LINE_COL_BITS;
    localparam int M_TDATA_BITS  = ((TOKEN_BITS + 7) / 8) * 8;

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [LINE_COL_BITS-1:0] t_lc;
    typedef logic [LEN_BITS-1:0]      t_len;
    typedef logic [KW_BITS-1:0]       t_kw;

    localparam t_pos POS_MAX = '1;
    localparam t_lc  LC_MAX  = '1;
    localparam t_len LEN_MAX = '1;
    localparam t_lc  LC_ONE  = t_lc'(1);
    localparam t_len LEN_ONE = t_len'(1);

    // Keyword matcher codes: 0..5 bytes of "print" matched, dead otherwise
    localparam t_kw  KW_NONE = t_kw'(0);
    localparam t_kw  KW_ONE  = t_kw'(1);
    localparam t_kw  KW_FULL = t_kw'(5);
    localparam t_kw  KW_DEAD = t_kw'(7);
    localparam t_len KW_LEN  = t_len'(5);

    // Characters
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [3:0] {
        TK_NUMBER = 4'd0,
        TK_IDENT  = 4'd1,
        TK_PLUS   = 4'd2,
        TK_MINUS  = 4'd3,
        TK_MUL    = 4'd4,
        TK_DIV    = 4'd5,
        TK_ASSIGN = 4'd6,
        TK_LPAREN = 4'd7,
        TK_RPAREN = 4'd8,
        TK_SEMI   = 4'd9,
        TK_PRINT  = 4'd10,
        TK_END    = 4'd11,
        TK_ERROR  = 4'd12
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind kind;
        t_pos      offset;
        t_len      length;
        t_lc       line;
        t_lc       column;
        logic      last;
    } t_token;

    // Up to two tokens per input byte, in order tok0 then tok1
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_emit;

    // Byte of the keyword "print" at a given match position
    function automatic logic [7:0] kw_char(input t_kw idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h70;  // p
            3'd1:    ch = 8'h72;  // r
            3'd2:    ch = 8'h69;  // i
            3'd3:    ch = 8'h6E;  // n
            3'd4:    ch = 8'h74;  // t
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/etl_core.sv]
// Lexer state and per-byte token decision for the expression token lexer.
// Depends on etl_pkg. Produces up to two tokens per input word.
module etl_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,    // process the held word this cycle
    input  logic            i_kind,    // 1 = end of input
    input  logic [7:0]      i_byte,
    output etl_pkg::t_emit  o_emit
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_ERR   = 2'd3
    } t_mode;

    t_mode           r_mode,     n_mode;
    etl_pkg::t_pos   r_pos,      n_pos;
    etl_pkg::t_lc    r_line,     n_line;
    etl_pkg::t_lc    r_col,      n_col;
    etl_pkg::t_pos   r_pend_off, n_pend_off;
    etl_pkg::t_lc    r_pend_col, n_pend_col;
    etl_pkg::t_len   r_len,      n_len;
    etl_pkg::t_kw    r_kw,       n_kw;

    logic            is_dig, is_alpha, is_us, is_space, is_nl, is_dot;
    logic            op_hit;
    etl_pkg::t_tok_kind op_kind;
    etl_pkg::t_pos   pos_adv;
    etl_pkg::t_lc    line_adv, col_adv;
    etl_pkg::t_len   len_inc;
    logic            has_pending;
    logic            flush_v, sec_v;
    etl_pkg::t_token flush_tok, sec_tok;

    // Character classes
    assign is_dig   = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_alpha = ((i_byte >= 8'h61) && (i_byte <= 8'h7A)) ||
                      ((i_byte >= 8'h41) && (i_byte <= 8'h5A));
    assign is_us    = (i_byte == etl_pkg::CH_US);
    assign is_dot   = (i_byte == etl_pkg::CH_DOT);
    assign is_nl    = (i_byte == etl_pkg::CH_NL);
    assign is_space = (i_byte == etl_pkg::CH_SPACE) ||
                      ((i_byte >= etl_pkg::CH_TAB) && (i_byte <= etl_pkg::CH_CR));

    // Single-character operators
    always_comb begin
        op_hit  = 1'b1;
        op_kind = etl_pkg::TK_ERROR;
        unique case (i_byte)
            etl_pkg::CH_PLUS:   op_kind = etl_pkg::TK_PLUS;
            etl_pkg::CH_MINUS:  op_kind = etl_pkg::TK_MINUS;
            etl_pkg::CH_STAR:   op_kind = etl_pkg::TK_MUL;
            etl_pkg::CH_SLASH:  op_kind = etl_pkg::TK_DIV;
            etl_pkg::CH_EQ:     op_kind = etl_pkg::TK_ASSIGN;
            etl_pkg::CH_LPAREN: op_kind = etl_pkg::TK_LPAREN;
            etl_pkg::CH_RPAREN: op_kind = etl_pkg::TK_RPAREN;
            etl_pkg::CH_SEMI:   op_kind = etl_pkg::TK_SEMI;
            default:            op_hit  = 1'b0;
        endcase
    end

    // Saturating position advance over the current byte
    assign pos_adv  = (r_pos != etl_pkg::POS_MAX) ? r_pos + 1'b1 : r_pos;
    assign line_adv = (is_nl && (r_line != etl_pkg::LC_MAX)) ? r_line + 1'b1 : r_line;
    assign col_adv  = is_nl ? etl_pkg::LC_ONE :
                      ((r_col != etl_pkg::LC_MAX) ? r_col + 1'b1 : r_col);
    assign len_inc  = (r_len != etl_pkg::LEN_MAX) ? r_len + 1'b1 : r_len;

    assign has_pending = (r_mode == MODE_NUM) || (r_mode == MODE_IDENT);

    // Pending number or identifier as it would be flushed now
    always_comb begin
        flush_tok.kind   = (r_mode == MODE_NUM) ? etl_pkg::TK_NUMBER :
                           ((r_kw == etl_pkg::KW_FULL) && (r_len == etl_pkg::KW_LEN)) ?
                           etl_pkg::TK_PRINT : etl_pkg::TK_IDENT;
        flush_tok.offset = r_pend_off;
        flush_tok.length = r_len;
        flush_tok.line   = r_line;
        flush_tok.column = r_pend_col;
        flush_tok.last   = 1'b0;
    end

    // Next state and second token
    always_comb begin
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_line     = r_line;
        n_col      = r_col;
        n_pend_off = r_pend_off;
        n_pend_col = r_pend_col;
        n_len      = r_len;
        n_kw       = r_kw;
        flush_v    = 1'b0;
        sec_v      = 1'b0;
        sec_tok.kind   = etl_pkg::TK_ERROR;
        sec_tok.offset = r_pos;
        sec_tok.length = etl_pkg::LEN_ONE;
        sec_tok.line   = r_line;
        sec_tok.column = r_col;
        sec_tok.last   = 1'b1;

        priority if (i_kind) begin
            // end of input: flush, end token, back to reset state
            flush_v        = has_pending;
            sec_v          = 1'b1;
            sec_tok.kind   = etl_pkg::TK_END;
            sec_tok.length = '0;
            n_mode         = MODE_IDLE;
            n_pos          = '0;
            n_line         = etl_pkg::LC_ONE;
            n_col          = etl_pkg::LC_ONE;
            n_pend_off     = '0;
            n_pend_col     = etl_pkg::LC_ONE;
            n_len          = '0;
            n_kw           = etl_pkg::KW_NONE;
        end else if (r_mode == MODE_ERR) begin
            n_pos  = pos_adv;
            n_line = line_adv;
            n_col  = col_adv;
        end else if ((r_mode == MODE_NUM) && (is_dig || is_dot)) begin
            n_len  = len_inc;
            n_pos  = pos_adv;
            n_line = line_adv;
            n_col  = col_adv;
        end else if ((r_mode == MODE_IDENT) && (is_alpha || is_dig || is_us)) begin
            n_kw   = ((r_kw < etl_pkg::KW_FULL) && (i_byte == etl_pkg::kw_char(r_kw))) ?
                     r_kw + 1'b1 : etl_pkg::KW_DEAD;
            n_len  = len_inc;
            n_pos  = pos_adv;
            n_line = line_adv;
            n_col  = col_adv;
        end else begin
            // token boundary: flush, then treat the byte as from idle
            flush_v = has_pending;
            n_mode  = MODE_IDLE;
            n_len   = '0;
            n_kw    = etl_pkg::KW_NONE;
            n_pos   = pos_adv;
            n_line  = line_adv;
            n_col   = col_adv;
            priority if (is_space) begin
                n_mode = MODE_IDLE;
            end else if (is_dig) begin
                n_mode     = MODE_NUM;
                n_pend_off = r_pos;
                n_pend_col = r_col;
                n_len      = etl_pkg::LEN_ONE;
            end else if (is_alpha || is_us) begin
                n_mode     = MODE_IDENT;
                n_pend_off = r_pos;
                n_pend_col = r_col;
                n_len      = etl_pkg::LEN_ONE;
                n_kw       = (i_byte == etl_pkg::kw_char(etl_pkg::KW_NONE)) ?
                             etl_pkg::KW_ONE : etl_pkg::KW_DEAD;
            end else if (op_hit) begin
                sec_v        = 1'b1;
                sec_tok.kind = op_kind;
            end else begin
                sec_v        = 1'b1;
                sec_tok.kind = etl_pkg::TK_ERROR;
                n_mode       = MODE_ERR;
            end
        end
    end

    // Pack tokens in order; last marks the final one
    always_comb begin
        o_emit.tok0      = flush_v ? flush_tok : sec_tok;
        o_emit.tok0.last = !(flush_v && sec_v);
        o_emit.tok1      = sec_tok;
        o_emit.count     = i_fire ? {flush_v && sec_v, flush_v ^ sec_v} : 2'd0;
    end

    // Lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_pos      <= '0;
            r_line     <= etl_pkg::LC_ONE;
            r_col      <= etl_pkg::LC_ONE;
            r_pend_off <= '0;
            r_pend_col <= etl_pkg::LC_ONE;
            r_len      <= '0;
            r_kw       <= etl_pkg::KW_NONE;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_line     <= n_line;
            r_col      <= n_col;
            r_pend_off <= n_pend_off;
            r_pend_col <= n_pend_col;
            r_len      <= n_len;
            r_kw       <= n_kw;
        end
    end

`ifndef ASSERT_OFF
    // Dropping after an error: bytes never produce tokens
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_kind && (r_mode == MODE_ERR)) |-> (o_emit.count == 2'd0))
        else $error("etl_core: token produced while dropping after error");

    // End of input always finishes with the end token
    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind) |->
        (((o_emit.count == 2'd1) && (o_emit.tok0.kind == etl_pkg::TK_END)) ||
         ((o_emit.count == 2'd2) && (o_emit.tok1.kind == etl_pkg::TK_END))))
        else $error("etl_core: end of input without end token");

    // End of input returns the counters to their start values
    a_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind) |=>
        ((r_pos == '0) && (r_line == etl_pkg::LC_ONE) && (r_col == etl_pkg::LC_ONE) &&
         (r_mode == MODE_IDLE)))
        else $error("etl_core: state not cleared after end of input");
`endif

endmodule

[rtl/etl_rfifo.sv]
// Small result queue: takes up to two tokens per cycle, gives one per cycle while the reader is ready.
// Depends on etl_pkg.
module etl_rfifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_n,  // tokens written this cycle
    input  etl_pkg::t_token i_tok0,
    input  etl_pkg::t_token i_tok1,
    output logic            o_room,    // space for two more tokens
    output logic            o_valid,
    input  logic            i_ready,
    output etl_pkg::t_token o_tok
);

    localparam int CNT_BITS = etl_pkg::RES_PTR_BITS + 1;

    etl_pkg::t_token                  r_mem [etl_pkg::RES_DEPTH];
    logic [etl_pkg::RES_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [etl_pkg::RES_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [etl_pkg::RES_PTR_BITS-1:0] wr_ptr1;
    logic [CNT_BITS-1:0]              r_count, n_count;
    logic                             pop;

    assign o_valid  = (r_count != '0);
    assign o_tok    = r_mem[r_rd_ptr];
    assign o_room   = (r_count <= CNT_BITS'(etl_pkg::RES_DEPTH - 2));
    assign pop      = o_valid && i_ready;
    assign wr_ptr1  = r_wr_ptr + 1'b1;
    assign n_wr_ptr = r_wr_ptr + etl_pkg::RES_PTR_BITS'(i_push_n);
    assign n_rd_ptr = r_rd_ptr + etl_pkg::RES_PTR_BITS'(pop);
    assign n_count  = r_count + CNT_BITS'(i_push_n) - CNT_BITS'(pop);

    // Token storage
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_tok0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_ptr1] <= i_tok1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    // Fill level stays within the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(etl_pkg::RES_DEPTH))
        else $error("etl_rfifo: fill level beyond depth");

    // Writes only arrive when two entries are free
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> o_room)
        else $error("etl_rfifo: push without room");
`endif

endmodule

[rtl/expression_token_lexer.sv]
// Top level of the expression token lexer: input register, lexer core and
// result queue. Depends on etl_pkg, etl_core and etl_rfifo.

// Takes one source byte (tuser = 0) or an end-of-input word (tuser = 1) per
// cycle and emits tokens with kind, start offset, length, line and column.
// A word is registered on acceptance and decoded, once the queue has room,
// into zero, one or two tokens, which enter a four-entry result queue; the
// first token of a word passes the input register and the queue storage
// before it is offered on the output. Input is taken at one word per cycle as
// long as the queue has room for two tokens. Output drains one token per cycle
// while tready is high, so a word that both closes a pending number or
// identifier and yields a token of its own (an operator, an error, or end of
// input) outpaces the output when traffic is sustained. tlast marks the last
// token produced by one input word. After an unknown byte, bytes are dropped
// (still counted in offset, line and column) until end of input, which always
// returns the lexer to its reset state. Offset, line, column and token length
// saturate at their maximum values.
module expression_token_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_req
    input  logic [0:0]  i_s_tuser,   // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [etl_pkg::M_TDATA_BITS-1:0] o_m_tdata,
    // [23:0] start_offset, [39:24] token_length, [55:40] tok_line,
    // [71:56] tok_column
    output logic [3:0]  o_m_tuser,   // [3:0] token_kind
    output logic        o_m_tlast    // last
);

    logic            r_in_valid;
    logic            r_in_kind;
    logic [7:0]      r_in_byte;
    logic            s_accept;
    logic            fire;
    logic            room;
    etl_pkg::t_emit  emit;
    etl_pkg::t_token out_tok;

    // Input register
    assign fire       = r_in_valid && room;
    assign o_s_tready = !r_in_valid || fire;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_kind <= i_s_tuser[0];
            r_in_byte <= i_s_tdata;
        end
    end

    // Token decision
    etl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_kind  (r_in_kind),
        .i_byte  (r_in_byte),
        .o_emit  (emit)
    );

    // Result queue
    etl_rfifo u_rfifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (emit.count),
        .i_tok0   (emit.tok0),
        .i_tok1   (emit.tok1),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_tok    (out_tok)
    );

    // Output word packing
    assign o_m_tdata = etl_pkg::M_TDATA_BITS'({out_tok.column, out_tok.line,
                                               out_tok.length, out_tok.offset});
    assign o_m_tuser = out_tok.kind;
    assign o_m_tlast = out_tok.last;

endmodule
